// ===== rtl/core/iee_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_pkg
// Shared codes, types and defaults for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned StackDepthDefault = 32;

  // Token codes.
  localparam logic [3:0] TOK_VALUE  = 4'd0;
  localparam logic [3:0] TOK_ADD    = 4'd1;
  localparam logic [3:0] TOK_SUB    = 4'd2;
  localparam logic [3:0] TOK_MUL    = 4'd3;
  localparam logic [3:0] TOK_DIV    = 4'd4;
  localparam logic [3:0] TOK_MOD    = 4'd5;
  localparam logic [3:0] TOK_LPAREN = 4'd6;
  localparam logic [3:0] TOK_RPAREN = 4'd7;
  localparam logic [3:0] TOK_LBRACE = 4'd8;
  localparam logic [3:0] TOK_RBRACE = 4'd9;
  localparam logic [3:0] TOK_END    = 4'd10;
  localparam logic [3:0] TOK_RDATA  = 4'd11;

  // Operator stack codes.
  localparam logic [2:0] OPS_ADD    = 3'd1;
  localparam logic [2:0] OPS_SUB    = 3'd2;
  localparam logic [2:0] OPS_MUL    = 3'd3;
  localparam logic [2:0] OPS_DIV    = 3'd4;
  localparam logic [2:0] OPS_MOD    = 3'd5;
  localparam logic [2:0] OPS_LPAREN = 3'd6;
  localparam logic [2:0] OPS_LBRACE = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISSING  = 3'd1;
  localparam logic [2:0] ERR_PAREN    = 3'd2;
  localparam logic [2:0] ERR_BRACE    = 3'd3;
  localparam logic [2:0] ERR_DEREF    = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  // Datapath commands.
  typedef struct packed {
    logic       push_val;   // push cmd.data onto value stack
    logic       push_op;    // push cmd.opcode onto operator stack
    logic       pop_op;     // drop top operator
    logic       start_alu;  // begin applying top operator to top two values
    logic       write_top;  // overwrite top value with cmd.data
    logic       clear;      // empty both stacks
    logic [2:0] opcode;
    logic [15:0] data;
  } iee_cmd_t;

  // Datapath status.
  typedef struct packed {
    logic        val_full;
    logic        op_full;
    logic        val_empty;
    logic        val_lt2;
    logic        op_empty;
    logic [2:0]  op_top;
    logic        top_valid;  // top-of-stack registers hold fresh data
    logic        alu_busy;
    logic [15:0] val_top;
  } iee_sts_t;

  function automatic logic prec_hi(input logic [2:0] code);
    prec_hi = (code >= OPS_MUL);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/infix_expression_evaluator.sv =====
`default_nettype none
// Each operator applied runs through the ALU: add/sub use the ALU start register, mul adds
// a product register, and div/mod use the serial divider (one bit a cycle).
// Throughput: one token at a time; the next token waits for the reductions of the last.
// A result transaction is held in an output register; a new token is not taken until it leaves.
// Reset (rst_n low, synchronous) empties both stacks, clears the error and the read wait.
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Shunting-yard evaluator of 16-bit infix tokens with dereference reads.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = iee_pkg::StackDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [15:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [15:0]      out_value_res,
  output logic [2:0]       out_error
);
  import iee_pkg::*;

  // The controller sequences each token; the datapath owns the stacks and ALU.
  iee_cmd_t cmd;
  iee_sts_t sts;

  iee_control u_ctl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_value_res(out_value_res), .out_error(out_error),
    .cmd(cmd), .sts(sts)
  );

  iee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts)
  );
endmodule
`default_nettype wire

// ===== rtl/core/iee_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_divider
// Restoring 16-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [15:0]      quotient,
  output logic [15:0]      remainder
);
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [15:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic [16:0] trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    trial    = {rem_r, q_r[15]} - {1'b0, d_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      q_nxt    = dividend;
      rem_nxt  = 16'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial[16]) begin
        rem_nxt = {rem_r[14:0], q_r[15]};
        q_nxt   = {q_r[14:0], 1'b0};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[14:0], 1'b1};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule
`default_nettype wire

// ===== rtl/core/iee_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_datapath
// Value and operator stacks in memories, with the arithmetic unit.
// ----------------------------------------------------------------------------
module iee_datapath #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire iee_pkg::iee_cmd_t cmd,
  output iee_pkg::iee_sts_t     sts
);
  import iee_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  // Memory reads are registered, so the top of each stack is kept in flops
  // (ta_r = top value, tb_r = second value, to_r = top operator); after a pop
  // tb_r and to_r are refilled from memory.
  logic [15:0] vmem [STACK_DEPTH];
  logic [2:0]  omem [STACK_DEPTH];

  logic [CW-1:0] vcnt_r, vcnt_nxt, ocnt_r, ocnt_nxt;
  logic [15:0]   ta_r, ta_nxt, tb_r, tb_nxt;
  logic [2:0]    to_r, to_nxt;
  logic [15:0]   vrd_r;
  logic [2:0]    ord_r;
  logic          vfill_r, vfill_nxt, ofill_r, ofill_nxt;
  // ALU sequencing
  logic          alu_r, alu_nxt;
  logic          divw_r, divw_nxt;
  logic [2:0]    aop_r, aop_nxt;
  logic [15:0]   aa_r, ab_r;
  logic [31:0]   prod_r;
  logic          mulw_r, mulw_nxt;
  logic          dstart;
  logic          dbusy, ddone;
  logic [15:0]   dq, drem;
  logic          vwe;
  logic [AW-1:0] vwa, vra;
  logic [15:0]   vwd;
  logic          owe;
  logic [AW-1:0] owa, ora;
  logic          res_en;
  logic [15:0]   res;

  iee_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart),
    .dividend(aa_r), .divisor(ab_r),
    .busy(dbusy), .done(ddone), .quotient(dq), .remainder(drem)
  );

  always_comb begin
    vcnt_nxt  = vcnt_r;
    ocnt_nxt  = ocnt_r;
    ta_nxt    = ta_r;
    tb_nxt    = tb_r;
    to_nxt    = to_r;
    vfill_nxt = 1'b0;
    ofill_nxt = 1'b0;
    alu_nxt   = alu_r;
    divw_nxt  = divw_r;
    mulw_nxt  = 1'b0;
    aop_nxt   = aop_r;
    dstart    = 1'b0;
    vwe = 1'b0; vwa = '0; vwd = ta_r;
    owe = 1'b0; owa = '0;
    vra = '0; ora = '0;
    res_en = 1'b0;
    res    = 16'd0;

    // Refill of the second-value and top-operator registers after a pop.
    if (vfill_r) tb_nxt = vrd_r;
    if (ofill_r) to_nxt = ord_r;

    // Operands were latched at start; the result lands on the collapsed stack.
    if (mulw_r) begin
      res_en = 1'b1; res = prod_r[15:0];
    end
    if (ddone) begin
      res_en = 1'b1;
      if (ab_r == 16'd0) res = (aop_r == OPS_DIV) ? 16'hFFFF : aa_r;
      else res = (aop_r == OPS_DIV) ? dq : drem;
    end

    if (alu_r) begin
      unique case (aop_r)
        OPS_ADD: begin res_en = 1'b1; res = aa_r + ab_r; end
        OPS_SUB: begin res_en = 1'b1; res = aa_r - ab_r; end
        OPS_MUL: mulw_nxt = 1'b1;
        default: begin dstart = 1'b1; divw_nxt = 1'b1; end
      endcase
      alu_nxt = 1'b0;
    end
    if (res_en) begin
      ta_nxt   = res;
      divw_nxt = 1'b0;
    end

    if (cmd.clear) begin
      vcnt_nxt = '0;
      ocnt_nxt = '0;
    end else begin
      if (cmd.push_val) begin
        // Spill old top into memory at its own slot.
        if (vcnt_r != '0) begin
          vwe = 1'b1; vwa = AW'(vcnt_r - CW'(1)); vwd = ta_r;
        end
        tb_nxt   = ta_r;
        ta_nxt   = cmd.data;
        vcnt_nxt = vcnt_r + CW'(1);
      end
      if (cmd.write_top) ta_nxt = cmd.data;
      if (cmd.push_op) begin
        if (ocnt_r != '0) begin
          owe = 1'b1; owa = AW'(ocnt_r - CW'(1));
        end
        to_nxt   = cmd.opcode;
        ocnt_nxt = ocnt_r + CW'(1);
      end
      if (cmd.pop_op || cmd.start_alu) begin
        ocnt_nxt = ocnt_r - CW'(1);
        if (ocnt_r >= CW'(2)) begin
          ora = AW'(ocnt_r - CW'(2));
          ofill_nxt = 1'b1;
        end
      end
      if (cmd.start_alu) begin
        aop_nxt  = to_r;
        alu_nxt  = 1'b1;
        vcnt_nxt = vcnt_r - CW'(1);
        // The second value becomes the new top; the one under it is fetched.
        ta_nxt   = tb_r;
        if (vcnt_r >= CW'(3)) begin
          vra = AW'(vcnt_r - CW'(3));
          vfill_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vwe) vmem[vwa] <= vwd;
    if (owe) omem[owa] <= to_r;
    vrd_r <= vmem[vra];
    ord_r <= omem[ora];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r  <= '0;
      ocnt_r  <= '0;
      vfill_r <= 1'b0;
      ofill_r <= 1'b0;
      alu_r   <= 1'b0;
      divw_r  <= 1'b0;
      mulw_r  <= 1'b0;
    end else begin
      vcnt_r  <= vcnt_nxt;
      ocnt_r  <= ocnt_nxt;
      vfill_r <= vfill_nxt;
      ofill_r <= ofill_nxt;
      alu_r   <= alu_nxt;
      divw_r  <= divw_nxt;
      mulw_r  <= mulw_nxt;
    end
    ta_r   <= ta_nxt;
    tb_r   <= tb_nxt;
    to_r   <= to_nxt;
    aop_r  <= aop_nxt;
    if (cmd.start_alu) begin
      aa_r <= tb_r;
      ab_r <= ta_r;
    end
    prod_r <= aa_r * ab_r;
  end

  always_comb begin
    sts.val_full  = (vcnt_r == FULL);
    sts.op_full   = (ocnt_r == FULL);
    sts.val_empty = (vcnt_r == '0);
    sts.val_lt2   = (vcnt_r < CW'(2));
    sts.op_empty  = (ocnt_r == '0);
    sts.op_top    = to_r;
    sts.top_valid = !vfill_r && !ofill_r;
    sts.alu_busy  = alu_r || mulw_r || divw_r || dbusy || ddone;
    sts.val_top   = ta_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_alu |-> !sts.val_lt2)
    else $error("ALU started with fewer than two values");
  assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= FULL && ocnt_r <= FULL)
    else $error("stack count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_alu |=> !cmd.start_alu)
    else $error("ALU restarted while busy");
endmodule
`default_nettype wire

// ===== rtl/core/iee_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iee_control
// Token sequencer: decides pushes, reductions, requests and results.
// ----------------------------------------------------------------------------
module iee_control (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        in_op,
  input  wire logic [15:0]       in_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_kind,
  output logic [15:0]            out_value_res,
  output logic [2:0]             out_error,
  output iee_pkg::iee_cmd_t      cmd,
  input  wire iee_pkg::iee_sts_t sts
);
  import iee_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OPER  = 3'd1; // reducing before an operator push
  localparam logic [2:0] S_RPAR  = 3'd2;
  localparam logic [2:0] S_RBRC  = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  tok_r, tok_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        await_r, await_nxt;
  logic        ov_r, ov_nxt;
  logic        ok_r, ok_nxt;
  logic        ok_s;
  logic [15:0] ov_val_r, ov_val_nxt;
  logic        ov_kind_r, ov_kind_nxt;
  logic [2:0]  ov_err_r, ov_err_nxt;
  logic        acc, ready, emit;
  logic [2:0]  top;
  logic        is_bin;

  assign ready    = sts.top_valid && !sts.alu_busy && !ov_r;
  assign in_stall = !(st_r == S_IDLE && ready);
  assign acc      = in_valid && !in_stall;
  assign top      = sts.op_top;
  assign is_bin   = (top >= OPS_ADD) && (top <= OPS_MOD);
  assign ok_s     = ok_r;

  always_comb begin
    st_nxt      = st_r;
    tok_nxt     = tok_r;
    err_nxt     = err_r;
    await_nxt   = await_r;
    ov_nxt      = ov_r;
    ok_nxt      = ok_r;
    ov_val_nxt  = ov_val_r;
    ov_kind_nxt = ov_kind_r;
    ov_err_nxt  = ov_err_r;
    emit        = 1'b0;
    cmd         = '0;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          tok_nxt = in_op;
          if (in_op == TOK_END) begin
            st_nxt = S_END;
          end else if (err_r != ERR_NONE) begin
            st_nxt = S_IDLE;
          end else if (await_r) begin
            if (in_op == TOK_RDATA) begin
              if (!sts.val_empty) begin
                cmd.write_top = 1'b1;
                cmd.data = {8'd0, in_value[7:0]};
              end
              await_nxt = 1'b0;
            end
          end else begin
            unique case (in_op)
              TOK_VALUE: begin
                if (sts.val_full) err_nxt = ERR_OVERFLOW;
                else begin cmd.push_val = 1'b1; cmd.data = in_value; end
              end
              TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_MOD: st_nxt = S_OPER;
              TOK_LPAREN, TOK_LBRACE: begin
                if (sts.op_full) err_nxt = ERR_OVERFLOW;
                else begin
                  cmd.push_op = 1'b1;
                  cmd.opcode  = (in_op == TOK_LPAREN) ? OPS_LPAREN : OPS_LBRACE;
                end
              end
              TOK_RPAREN: st_nxt = S_RPAR;
              TOK_RBRACE: st_nxt = S_RBRC;
              default: st_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_OPER: if (ready) begin
        if (!sts.op_empty && is_bin && (prec_hi(top) || !prec_hi(tok_r[2:0]))) begin
          if (sts.val_lt2) begin err_nxt = ERR_MISSING; st_nxt = S_IDLE; end
          else cmd.start_alu = 1'b1;
        end else begin
          if (sts.op_full) err_nxt = ERR_OVERFLOW;
          else begin cmd.push_op = 1'b1; cmd.opcode = tok_r[2:0]; end
          st_nxt = S_IDLE;
        end
      end

      S_RPAR, S_RBRC: if (ready) begin
        if (sts.op_empty || (top == ((st_r == S_RPAR) ? OPS_LBRACE : OPS_LPAREN))) begin
          err_nxt = (st_r == S_RPAR) ? ERR_PAREN : ERR_BRACE;
          st_nxt  = S_IDLE;
        end else if (top == ((st_r == S_RPAR) ? OPS_LPAREN : OPS_LBRACE)) begin
          cmd.pop_op = 1'b1;
          st_nxt     = S_IDLE;
          if (st_r == S_RBRC) begin
            if (sts.val_empty) err_nxt = ERR_DEREF;
            else begin
              await_nxt   = 1'b1;
              emit        = 1'b1;
              ov_kind_nxt = 1'b1;
              ov_val_nxt  = sts.val_top;
              ov_err_nxt  = ERR_NONE;
            end
          end
        end else if (sts.val_lt2) begin
          err_nxt = ERR_MISSING; st_nxt = S_IDLE;
        end else cmd.start_alu = 1'b1;
      end

      S_END: if (ready) begin
        if (err_r == ERR_NONE && !sts.op_empty && ok_s) begin
          if (top == OPS_LPAREN) begin err_nxt = ERR_PAREN; ok_nxt = 1'b0; end
          else if (top == OPS_LBRACE) begin err_nxt = ERR_BRACE; ok_nxt = 1'b0; end
          else if (sts.val_lt2) begin err_nxt = ERR_MISSING; ok_nxt = 1'b0; end
          else cmd.start_alu = 1'b1;
        end else begin
          emit        = 1'b1;
          ov_kind_nxt = 1'b0;
          ov_err_nxt  = err_r;
          ov_val_nxt  = (err_r == ERR_NONE && !sts.val_empty) ? sts.val_top : 16'd0;
          cmd.clear   = 1'b1;
          err_nxt     = ERR_NONE;
          await_nxt   = 1'b0;
          ok_nxt      = 1'b1;
          st_nxt      = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
    if (emit) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      err_r   <= ERR_NONE;
      await_r <= 1'b0;
      ov_r    <= 1'b0;
      ok_r    <= 1'b1;
    end else begin
      st_r    <= st_nxt;
      err_r   <= err_nxt;
      await_r <= await_nxt;
      ov_r    <= ov_nxt;
      ok_r    <= ok_nxt;
    end
    tok_r     <= tok_nxt;
    ov_val_r  <= ov_val_nxt;
    ov_kind_r <= ov_kind_nxt;
    ov_err_r  <= ov_err_nxt;
  end

  assign out_valid     = ov_r;
  assign out_kind      = ov_kind_r;
  assign out_value_res = ov_val_r;
  assign out_error     = ov_kind_r ? ERR_NONE : ov_err_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> st_r == S_IDLE)
    else $error("token taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !ov_r)
    else $error("result overwrote pending transaction");
  assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE && st_r == S_IDLE) |-> !cmd.start_alu && !cmd.push_val)
    else $error("stack changed after error");
endmodule
`default_nettype wire

// ===== test/infix_expression_evaluator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_expression_evaluator_test
// Self-checking bench for the infix expression evaluator. Directed token
// sequences cover the extremes and every error path. Random well-formed
// expressions with noise follow. Each result transaction is compared with a
// behavioral model of the evaluator kept in this file or a typed-in result.
// ----------------------------------------------------------------------------
module infix_expression_evaluator_test;
  import iee_pkg::*;

  localparam int unsigned Depth = StackDepthDefault;
  localparam int unsigned IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_op;
  logic [15:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [15:0] out_value_res;
  logic [2:0]  out_error;

  infix_expression_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_value_res(out_value_res), .out_error(out_error)
  );

  typedef struct packed {
    logic        kind;
    logic [15:0] value_res;
    logic [2:0]  error;
  } eval_result_t;

  // Model state of the evaluator.
  logic [15:0] vals [Depth];
  logic [2:0]  ops  [Depth];
  int unsigned nvals;
  int unsigned nops;
  logic [2:0]  err_code;
  logic        read_pending;

  eval_result_t pending_results[$];
  int unsigned  failures;
  int unsigned  idle_cycles;
  logic         drain_phase;   // no idling on either side at the end
  logic         hold_sink;     // receiver holds off for a long stretch

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] alu(input logic [2:0] code, input logic [15:0] a,
                                      input logic [15:0] b);
    case (code)
      OPS_ADD: alu = a + b;
      OPS_SUB: alu = a - b;
      OPS_MUL: alu = a * b;
      OPS_DIV: alu = (b == 16'd0) ? 16'hFFFF : a / b;
      OPS_MOD: alu = (b == 16'd0) ? a : a % b;
      default: alu = 16'd0;
    endcase
  endfunction

  task automatic flag(input logic [2:0] e);
    if (err_code == ERR_NONE) err_code = e;
  endtask

  task automatic clear_model();
    nvals = 0;
    nops = 0;
    err_code = ERR_NONE;
    read_pending = 1'b0;
  endtask

  task automatic apply_top(output logic ok);
    logic [2:0] code;
    if (nvals < 2) begin
      flag(ERR_MISSING);
      ok = 1'b0;
    end else begin
      code = ops[nops-1];
      nops--;
      vals[nvals-2] = alu(code, vals[nvals-2], vals[nvals-1]);
      nvals--;
      ok = 1'b1;
    end
  endtask

  // Reduces down to the given opener and pops it; raises e on a mismatch.
  task automatic reduce_to(input logic [2:0] opener, input logic [2:0] e, output logic ok);
    logic ap;
    ok = 1'b0;
    forever begin
      if (nops == 0) begin
        flag(e);
        return;
      end
      if (ops[nops-1] == opener) begin
        nops--;
        ok = 1'b1;
        return;
      end
      if (ops[nops-1] == OPS_LPAREN || ops[nops-1] == OPS_LBRACE) begin
        flag(e);
        return;
      end
      apply_top(ap);
      if (!ap) return;
    end
  endtask

  task automatic push_op(input logic [2:0] code);
    if (nops >= Depth) flag(ERR_OVERFLOW);
    else begin
      ops[nops] = code;
      nops++;
    end
  endtask

  // Advances the model by one token and queues any result it causes.
  task automatic evaluate_token(input logic [3:0] op, input logic [15:0] v);
    eval_result_t r;
    logic ok;
    if (op == TOK_END) begin
      if (err_code == ERR_NONE) begin
        while (nops > 0) begin
          if (ops[nops-1] == OPS_LPAREN) begin flag(ERR_PAREN); break; end
          if (ops[nops-1] == OPS_LBRACE) begin flag(ERR_BRACE); break; end
          apply_top(ok);
          if (!ok) break;
        end
      end
      r.kind = 1'b0;
      r.value_res = (err_code == ERR_NONE && nvals > 0) ? vals[nvals-1] : 16'd0;
      r.error = err_code;
      pending_results.push_back(r);
      clear_model();
      return;
    end
    if (err_code != ERR_NONE) return;
    if (read_pending) begin
      if (op == TOK_RDATA) begin
        if (nvals > 0) vals[nvals-1] = {8'd0, v[7:0]};
        read_pending = 1'b0;
      end
      return;
    end
    case (op)
      TOK_VALUE: begin
        if (nvals >= Depth) flag(ERR_OVERFLOW);
        else begin
          vals[nvals] = v;
          nvals++;
        end
      end
      TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV, TOK_MOD: begin
        // Left-associative: pop everything of equal or higher precedence.
        while (nops > 0) begin
          if (ops[nops-1] < OPS_ADD || ops[nops-1] > OPS_MOD) break;
          if (prec_hi(ops[nops-1]) < prec_hi(op[2:0])) break;
          apply_top(ok);
          if (!ok) return;
        end
        push_op(op[2:0]);
      end
      TOK_LPAREN: push_op(OPS_LPAREN);
      TOK_LBRACE: push_op(OPS_LBRACE);
      TOK_RPAREN: reduce_to(OPS_LPAREN, ERR_PAREN, ok);
      TOK_RBRACE: begin
        reduce_to(OPS_LBRACE, ERR_BRACE, ok);
        if (!ok) return;
        if (nvals < 1) begin
          flag(ERR_DEREF);
          return;
        end
        read_pending = 1'b1;
        r.kind = 1'b1;
        r.value_res = vals[nvals-1];
        r.error = ERR_NONE;
        pending_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Sends one token transaction; a random idle burst may come first.
  task automatic send_token(input logic [3:0] op, input logic [15:0] v);
    int unsigned gap;
    if (!drain_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    evaluate_token(op, v);
  endtask

  task automatic send_idle_last(input logic [3:0] op, input logic [15:0] v);
    send_token(op, v);
    in_valid <= 1'b0;
  endtask

  task automatic wait_empty();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Receiver: random stall bursts, none during the drain phase.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_sink = 1'b0;
      end else if (!drain_phase && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d value %h error %0d",
               out_kind, out_value_res, out_error);
        failures++;
      end else begin
        eval_result_t e;
        e = pending_results.pop_front();
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          failures++;
        end
        if (out_value_res !== e.value_res) begin
          $error("value_res: expected %h, got %h", e.value_res, out_value_res);
          failures++;
        end
        if (out_error !== e.error) begin
          $error("error: expected %0d, got %0d", e.error, out_error);
          failures++;
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Directed table: token, value, and a typed-in result where it is obvious.
  typedef struct {
    logic [3:0]  op;
    logic [15:0] v;
    logic        typed;
    eval_result_t want;
  } directed_row_t;

  directed_row_t table_rows[$];

  task automatic add_row(input logic [3:0] op, input logic [15:0] v, input logic typed = 1'b0,
                         input logic [15:0] rv = 16'd0, input logic [2:0] re = ERR_NONE);
    directed_row_t row;
    row.op = op;
    row.v = v;
    row.typed = typed;
    row.want = '{1'b0, rv, re};
    table_rows.push_back(row);
  endtask

  // Emits a random expression, sometimes with a dereference whose read data may be left out.
  task automatic random_operand(input int unsigned lvl);
    int unsigned pick;
    logic [15:0] v;
    pick = $urandom_range(0, 9);
    v = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    if (lvl < 3 && pick == 0) begin
      send_token(TOK_LPAREN, 16'($urandom));
      random_expr(lvl + 1);
      send_token(TOK_RPAREN, 16'($urandom));
    end else if (lvl < 3 && pick == 1) begin
      send_token(TOK_LBRACE, 16'($urandom));
      random_expr(lvl + 1);
      send_token(TOK_RBRACE, 16'($urandom));
      if ($urandom_range(0, 9) != 0) send_token(TOK_RDATA, 16'($urandom));
    end else begin
      send_token(TOK_VALUE, v);
    end
  endtask

  task automatic random_expr(input int unsigned lvl);
    int unsigned terms;
    terms = $urandom_range(1, 4);
    random_operand(lvl);
    repeat (terms - 1) begin
      send_token(4'($urandom_range(TOK_ADD, TOK_MOD)), 16'($urandom));
      random_operand(lvl);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned base;
    failures = 0;
    idle_cycles = 0;
    drain_phase = 1'b0;
    hold_sink = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = TOK_VALUE;
    in_value = 16'd0;
    clear_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // End right after reset, extreme values, division and modulo by zero, and each error but overflow.
    add_row(TOK_END, 16'hFFFF, 1'b1, 16'd0, ERR_NONE);
    add_row(TOK_VALUE, 16'hFFFF);
    add_row(TOK_DIV, 16'd0);
    add_row(TOK_VALUE, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'hFFFF, ERR_NONE);
    add_row(TOK_VALUE, 16'h1234);
    add_row(TOK_MOD, 16'd0);
    add_row(TOK_VALUE, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'h1234, ERR_NONE);
    add_row(TOK_ADD, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'd0, ERR_MISSING);
    add_row(TOK_RPAREN, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'd0, ERR_PAREN);
    add_row(TOK_RBRACE, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'd0, ERR_BRACE);
    add_row(TOK_LBRACE, 16'd0);
    add_row(TOK_RBRACE, 16'd0);
    add_row(TOK_END, 16'd0, 1'b1, 16'd0, ERR_DEREF);
    add_row(TOK_LBRACE, 16'd0);
    add_row(TOK_VALUE, 16'h0042);
    add_row(TOK_RBRACE, 16'd0);
    add_row(TOK_RDATA, 16'hABCD);
    add_row(TOK_SUB, 16'd0);
    add_row(4'd15, 16'd0);
    add_row(TOK_END, 16'd0);
    foreach (table_rows[i]) begin
      if (table_rows[i].typed) begin
        // The end token's expectation is the newest one in the queue.
        send_token(table_rows[i].op, table_rows[i].v);
        pending_results[pending_results.size() - 1] = table_rows[i].want;
      end else begin
        send_token(table_rows[i].op, table_rows[i].v);
      end
    end
    in_valid <= 1'b0;
    wait_empty();

    // Overflow of each stack, then a receiver hold-off with the sender still going.
    repeat (Depth + 1) send_token(TOK_VALUE, 16'($urandom));
    send_token(TOK_END, 16'd0);
    repeat (Depth + 1) send_token(TOK_LPAREN, 16'd0);
    send_idle_last(TOK_END, 16'd0);
    wait_empty();
    hold_sink = 1'b1;
    sent = 0;
    repeat (6) begin
      random_expr(0);
      send_token(TOK_END, 16'($urandom));
    end
    in_valid <= 1'b0;
    wait_empty();

    sent = 0;
    while (sent < 1350) begin
      base = $urandom_range(0, 9);
      if (sent > 1150) drain_phase = 1'b1;
      if (base < 7) begin
        random_expr(0);
        sent += 6;
      end else begin
        // Noise: any token at all, including end-only and unknown codes.
        repeat ($urandom_range(1, 8)) begin
          send_token(4'($urandom), 16'($urandom));
          sent++;
        end
      end
      send_token(TOK_END, 16'($urandom));
      sent++;
      if (!drain_phase && $urandom_range(0, 40) == 0) begin
        in_valid <= 1'b0;
        wait_empty();
      end
    end
    in_valid <= 1'b0;
    wait_empty();

    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
